[rtl/spsg_pkg.sv]
package spsg_pkg;

  // configuration field widths
  localparam int WAVE_W     = 3;
  localparam int LEVEL_W    = 15;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int SAMPLE_W   = 16;
  localparam int SYNC_W     = 16;

  // shared multiplier operand and product widths (holds a time word of up to 32 integer bits)
  localparam int MA_W = 34;
  localparam int MB_W = 25;
  localparam int MP_W = MA_W + MB_W;

  // working sample value, signed Q.31
  localparam int VAL_W = 34;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_TYPE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL           = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH_INV = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_INV        = 3'd4;

  // wave type codes
  localparam logic [WAVE_W-1:0] WAVE_RECT  = 3'd0;
  localparam logic [WAVE_W-1:0] WAVE_RAMP  = 3'd1;
  localparam logic [WAVE_W-1:0] WAVE_CYCLE = 3'd2;
  localparam logic [WAVE_W-1:0] WAVE_SINE  = 3'd3;
  localparam logic [WAVE_W-1:0] WAVE_SAW   = 3'd4;

  // reset values of the registers
  localparam logic [WAVE_W-1:0]  RST_WAVE_TYPE       = WAVE_RECT;
  localparam logic [LEVEL_W-1:0] RST_LEVEL           = 15'd4096;
  localparam logic [CFG_W-1:0]   RST_PULSE_WIDTH     = 24'd25600;
  localparam logic [CFG_W-1:0]   RST_PULSE_WIDTH_INV = 24'd167772;
  localparam logic [CFG_W-1:0]   RST_FADE_INV        = 24'd16384;

  typedef struct packed {
    logic [WAVE_W-1:0]  wave_type;
    logic [LEVEL_W-1:0] level;
    logic [CFG_W-1:0]   pulse_width;
    logic [CFG_W-1:0]   pulse_width_inv;
    logic [CFG_W-1:0]   fade_inv;
  } cfg_t;

  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] sample;
  } res_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_POS_HI,
    ST_POS_LO,
    ST_POS_SUM,
    ST_RECT_A,
    ST_RECT_B,
    ST_RAMP_A,
    ST_RAMP_B,
    ST_CYC_SEL,
    ST_SM_X2,
    ST_SM_X3,
    ST_SM_Q,
    ST_SM_R,
    ST_SM_L,
    ST_SAW_A,
    ST_SAW_B,
    ST_FADE_B,
    ST_FADE_C,
    ST_FADE_D,
    ST_FIN
  } core_state_e;

  // how the smoothstep result becomes the shape value
  typedef enum logic [1:0] {
    FORM_PLAIN,
    FORM_DOUBLE,
    FORM_MINUS
  } shape_form_e;

endpackage

[rtl/spsg_mul.sv]
module spsg_mul (
  input  logic                              clk_i,
  input  logic signed [spsg_pkg::MA_W-1:0]  a_i,
  input  logic signed [spsg_pkg::MB_W-1:0]  b_i,
  output logic signed [spsg_pkg::MP_W-1:0]  p_o
);

  logic signed [spsg_pkg::MP_W-1:0] p_q;
  logic signed [spsg_pkg::MP_W-1:0] p_d;

  // signed product, registered
  assign p_d = spsg_pkg::MP_W'(a_i) * spsg_pkg::MP_W'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

[rtl/spsg_core.sv]
module spsg_core #(
  parameter int unsigned TIME_INT_BITS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  spsg_pkg::cfg_t                   cfg_i,
  input  logic                             start_i,
  input  logic                             kind_i,
  input  logic [spsg_pkg::SYNC_W-1:0]      sync_age_i,
  output logic                             ready_o,
  input  logic                             out_free_i,
  output spsg_pkg::res_t                   res_o
);

  localparam int TW = TIME_INT_BITS + 16;
  localparam int AW = TIME_INT_BITS + 24;
  localparam int PW = TIME_INT_BITS + 17;
  localparam int DW = TW + 1;
  localparam int VW = spsg_pkg::VAL_W;
  localparam int MW = spsg_pkg::MP_W;

  localparam logic [TW-1:0]        IDLE_T    = '1;
  localparam logic [TW-1:0]        STEP_T    = TW'(65536);
  localparam logic [TW-1:0]        SAT_T     = IDLE_T - STEP_T;
  localparam logic signed [DW-1:0] DIF_ONE   = DW'(65536);
  localparam logic signed [MW-1:0] FADE_RND  = MW'(65535);
  localparam logic signed [VW:0]   ROUND_H   = (VW + 1)'(32768);
  localparam logic signed [18:0]   SAT_HI    = 19'sd32767;
  localparam logic signed [18:0]   SAT_LO    = -19'sd32768;

  // control state
  spsg_pkg::core_state_e state_q, state_d;
  logic [TW-1:0]         et_q, et_d;
  logic                  idle_q, idle_d;

  // working registers
  logic [AW-1:0]          a_q, a_d;
  logic [PW-1:0]          pos_q, pos_d;
  logic signed [DW-1:0]   dif_q, dif_d;
  logic signed [VW-1:0]   val_q, val_d;
  logic signed [VW-1:0]   w_q, w_d;
  logic [16:0]            x_q, x_d;
  logic [16:0]            x2_q, x2_d;
  logic [16:0]            amp_q, amp_d;
  spsg_pkg::shape_form_e  form_q, form_d;

  // shared multiplier
  logic signed [spsg_pkg::MA_W-1:0] mul_a;
  logic signed [spsg_pkg::MB_W-1:0] mul_b;
  logic signed [MW-1:0]             p_q;

  spsg_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (p_q)
  );

  // helper terms
  logic signed [VW-1:0]            big_l;
  logic signed [spsg_pkg::MB_W-1:0] lv_b;
  logic                            t_small;
  logic                            pos_lt2;
  logic                            pos_lt_half;
  logic                            dif_le1;
  logic [40:0]                     b_sum;
  logic [16:0]                     p16;
  logic [16:0]                     pm;
  logic [32:0]                     m_rect;
  logic signed [VW-1:0]            val0;
  logic [17:0]                     sm;
  logic signed [19:0]              sm_ext;
  logic signed [19:0]              shape_v;
  logic signed [17:0]              saw_v;
  logic [20:0]                     q_poly;
  logic signed [MW-1:0]            fade_adj;
  logic signed [VW:0]              rnd_sum;
  logic signed [18:0]              s_rnd;
  logic signed [spsg_pkg::SAMPLE_W-1:0] s_sat;

  assign big_l       = $signed(VW'({cfg_i.level, 16'b0}));
  assign lv_b        = $signed(spsg_pkg::MB_W'(cfg_i.level));
  assign t_small     = (et_q[TW-1:16] == '0);
  assign pos_lt2     = (pos_q[PW-1:17] == '0);
  assign pos_lt_half = (pos_q[PW-1:15] == '0);
  assign dif_le1     = (dif_q <= DIF_ONE);
  assign b_sum       = 41'({a_q[7:0], 16'b0}) + 41'(p_q[39:0]);
  assign p16         = pos_q[16:0];
  assign pm          = p16 - 17'd32768;

  // rectangle: level ramp inside the first sample, then the edge product operand
  assign val0   = t_small ? (-big_l + $signed(VW'({p_q[30:0], 1'b0}))) : big_l;
  assign m_rect = t_small ? {1'b0, p_q[30:0], 1'b0} : {1'b0, big_l[30:0], 1'b0};

  // smoothstep terms
  assign q_poly  = 21'({x2_q, 2'b0}) + 21'({x2_q, 1'b0}) + 21'd655360
                 - 21'({x_q, 4'b0}) + 21'(x_q);
  assign sm      = p_q[33:16];
  assign sm_ext  = $signed(20'(sm));
  assign saw_v   = $signed({1'b0, p16}) - 18'sd65536;

  always_comb begin
    case (form_q)
      spsg_pkg::FORM_DOUBLE: shape_v = (sm_ext <<< 1) - 20'sd65536;
      spsg_pkg::FORM_MINUS:  shape_v = sm_ext - 20'sd65536;
      default:               shape_v = sm_ext;
    endcase
  end

  // signed divide by 2^16 toward zero
  assign fade_adj = p_q + (p_q[MW-1] ? FADE_RND : '0);

  // round to nearest, ties up, and saturate to Q1.15
  assign rnd_sum = (VW + 1)'(val_q) + ROUND_H;
  assign s_rnd   = rnd_sum[VW:16];

  always_comb begin
    if (s_rnd > SAT_HI) begin
      s_sat = 16'sh7FFF;
    end else if (s_rnd < SAT_LO) begin
      s_sat = 16'sh8000;
    end else begin
      s_sat = s_rnd[15:0];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    et_d    = et_q;
    idle_d  = idle_q;
    a_d     = a_q;
    pos_d   = pos_q;
    dif_d   = dif_q;
    val_d   = val_q;
    w_d     = w_q;
    x_d     = x_q;
    x2_d    = x2_q;
    amp_d   = amp_q;
    form_d  = form_q;
    mul_a   = '0;
    mul_b   = '0;
    ready_o = 1'b0;
    res_o   = '0;

    case (state_q)
      spsg_pkg::ST_IDLE: begin
        ready_o = 1'b1;
        if (start_i) begin
          if (kind_i) begin
            et_d = TW'(sync_age_i);
          end
          idle_d  = 1'b0;
          state_d = spsg_pkg::ST_POS_HI;
        end
      end

      // pos = t * inv_width, integer part of t first
      spsg_pkg::ST_POS_HI: begin
        mul_a   = spsg_pkg::MA_W'(et_q[TW-1:16]);
        mul_b   = spsg_pkg::MB_W'(cfg_i.pulse_width_inv);
        dif_d   = $signed({1'b0, et_q}) - $signed(DW'({cfg_i.pulse_width, 8'b0}));
        state_d = spsg_pkg::ST_POS_LO;
      end

      spsg_pkg::ST_POS_LO: begin
        a_d     = p_q[AW-1:0];
        mul_a   = spsg_pkg::MA_W'(et_q[15:0]);
        mul_b   = spsg_pkg::MB_W'(cfg_i.pulse_width_inv);
        state_d = spsg_pkg::ST_POS_SUM;
      end

      spsg_pkg::ST_POS_SUM: begin
        pos_d = PW'(a_q[AW-1:8]) + PW'(b_sum[40:24]);
        mul_a = spsg_pkg::MA_W'(et_q[15:0]);
        mul_b = lv_b;
        case (cfg_i.wave_type)
          spsg_pkg::WAVE_RECT:  state_d = spsg_pkg::ST_RECT_A;
          spsg_pkg::WAVE_RAMP:  state_d = spsg_pkg::ST_RAMP_A;
          spsg_pkg::WAVE_CYCLE: state_d = spsg_pkg::ST_CYC_SEL;
          spsg_pkg::WAVE_SINE:  state_d = spsg_pkg::ST_CYC_SEL;
          spsg_pkg::WAVE_SAW:   state_d = spsg_pkg::ST_SAW_A;
          default: begin
            val_d   = '0;
            state_d = spsg_pkg::ST_FIN;
          end
        endcase
      end

      // rectangle with interpolated falling edge
      spsg_pkg::ST_RECT_A: begin
        val_d   = val0;
        mul_a   = spsg_pkg::MA_W'(m_rect);
        mul_b   = spsg_pkg::MB_W'(dif_q[16:0]);
        state_d = spsg_pkg::ST_RECT_B;
      end

      spsg_pkg::ST_RECT_B: begin
        if (!dif_q[DW-1]) begin
          if (dif_le1) begin
            val_d  = val_q - $signed(p_q[16 +: VW]);
            idle_d = 1'b1;
          end else begin
            val_d = -big_l;
          end
        end
        state_d = spsg_pkg::ST_FIN;
      end

      // two-width ramp
      spsg_pkg::ST_RAMP_A: begin
        mul_a   = spsg_pkg::MA_W'(p16);
        mul_b   = lv_b;
        state_d = spsg_pkg::ST_RAMP_B;
      end

      spsg_pkg::ST_RAMP_B: begin
        if (pos_lt2) begin
          val_d = -big_l + $signed(p_q[VW-1:0]);
        end else if (dif_le1) begin
          val_d  = big_l;
          idle_d = 1'b1;
        end else begin
          val_d = -big_l;
        end
        state_d = spsg_pkg::ST_FIN;
      end

      // pick the smoothstep argument and form
      spsg_pkg::ST_CYC_SEL: begin
        state_d = spsg_pkg::ST_SM_X2;
        if (pos_lt_half) begin
          x_d    = {1'b0, p16[14:0], 1'b0};
          form_d = spsg_pkg::FORM_PLAIN;
        end else if (cfg_i.wave_type == spsg_pkg::WAVE_CYCLE) begin
          if (!pos_lt2) begin
            val_d   = '0;
            idle_d  = 1'b1;
            state_d = spsg_pkg::ST_FIN;
          end else if (p16 < 17'd98304) begin
            x_d    = 17'd98304 - p16;
            form_d = spsg_pkg::FORM_DOUBLE;
          end else begin
            x_d    = {p16[15:0], 1'b0} - 17'd65536;
            form_d = spsg_pkg::FORM_MINUS;
          end
        end else begin
          x_d    = pm[16] ? {1'b0, pm[15:0]} : (17'd65536 - pm);
          form_d = spsg_pkg::FORM_DOUBLE;
        end
      end

      // smoothstep: x^2, x^3, x^3 * q, then times level
      spsg_pkg::ST_SM_X2: begin
        mul_a   = spsg_pkg::MA_W'(x_q);
        mul_b   = spsg_pkg::MB_W'(x_q);
        state_d = spsg_pkg::ST_SM_X3;
      end

      spsg_pkg::ST_SM_X3: begin
        x2_d    = p_q[32:16];
        mul_a   = spsg_pkg::MA_W'(p_q[32:16]);
        mul_b   = spsg_pkg::MB_W'(x_q);
        state_d = spsg_pkg::ST_SM_Q;
      end

      spsg_pkg::ST_SM_Q: begin
        mul_a   = spsg_pkg::MA_W'(p_q[32:16]);
        mul_b   = spsg_pkg::MB_W'(q_poly);
        state_d = spsg_pkg::ST_SM_R;
      end

      spsg_pkg::ST_SM_R: begin
        mul_a   = spsg_pkg::MA_W'(shape_v);
        mul_b   = lv_b;
        state_d = spsg_pkg::ST_SM_L;
      end

      // sawtooth before the fade
      spsg_pkg::ST_SAW_A: begin
        mul_a   = spsg_pkg::MA_W'(saw_v);
        mul_b   = lv_b;
        state_d = spsg_pkg::ST_SAW_B;
      end

      // shaped value ready: finish the single cycle, else start the fade
      spsg_pkg::ST_SM_L, spsg_pkg::ST_SAW_B: begin
        if (state_q == spsg_pkg::ST_SM_L && cfg_i.wave_type == spsg_pkg::WAVE_CYCLE) begin
          val_d   = $signed(p_q[VW-1:0]);
          state_d = spsg_pkg::ST_FIN;
        end else begin
          w_d     = $signed(p_q[VW-1:0]);
          mul_a   = spsg_pkg::MA_W'(pos_q[31:0]);
          mul_b   = spsg_pkg::MB_W'(cfg_i.fade_inv);
          state_d = spsg_pkg::ST_FADE_B;
        end
      end

      // fade amplitude 1 - min(1, pos * fade_inv)
      spsg_pkg::ST_FADE_B: begin
        if (cfg_i.fade_inv == '0) begin
          amp_d = 17'd65536;
        end else if ((pos_q[PW-1:32] != '0) || (p_q[55:32] != '0)) begin
          amp_d = '0;
        end else begin
          amp_d = 17'd65536 - {1'b0, p_q[31:16]};
        end
        state_d = spsg_pkg::ST_FADE_C;
      end

      spsg_pkg::ST_FADE_C: begin
        mul_a   = spsg_pkg::MA_W'(w_q);
        mul_b   = spsg_pkg::MB_W'(amp_q);
        state_d = spsg_pkg::ST_FADE_D;
      end

      spsg_pkg::ST_FADE_D: begin
        val_d   = $signed(fade_adj[16 +: VW]);
        state_d = spsg_pkg::ST_FIN;
      end

      // hand over the sample and advance time
      spsg_pkg::ST_FIN: begin
        if (out_free_i) begin
          res_o.valid  = 1'b1;
          res_o.sample = s_sat;
          if (idle_q || et_q >= SAT_T) begin
            et_d = IDLE_T;
          end else begin
            et_d = et_q + STEP_T;
          end
          state_d = spsg_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = spsg_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spsg_pkg::ST_IDLE;
      et_q    <= IDLE_T;
      idle_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      et_q    <= et_d;
      idle_q  <= idle_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    pos_q  <= pos_d;
    dif_q  <= dif_d;
    val_q  <= val_d;
    w_q    <= w_d;
    x_q    <= x_d;
    x2_q   <= x2_d;
    amp_q  <= amp_d;
    form_q <= form_d;
  end

endmodule

[rtl/synced_pulse_shape_generator.sv]
// Synced pulse shape generator.
// Input channel (in_valid_i / in_ready_o): one transfer per audio sample tick.
// kind_i = 1 restarts the elapsed time at sync_age_i (Q0.16 of a sample)
// before the sample is made; kind_i = 0 is a plain tick.
// Output channel (out_valid_o / out_ready_i): one Q1.15 sample per tick.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 wave type, 1 level, 2 pulse width, 3 pulse width reciprocal,
// 4 fade reciprocal); other indexes are ignored. Write only while idle.
// Timing: one item at a time through a single shared multiplier, one
// product per cycle. Each item runs its own sequence of steps by wave
// type (rect, ramp, single cycle, which ends early once past its end,
// faded multi-cycle, saw, unused type), and the next item is taken only
// once the last sample has been handed over. The sample is valid the
// cycle after its handover.
// The output register lets the next item start while a sample waits; a
// finished item holds until the output register frees up.
// Reset: registers return to defaults and elapsed time goes idle
// (all ones), so shapes read as idle until the first sync.
module synced_pulse_shape_generator #(
  parameter int unsigned TIME_INT_BITS = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [spsg_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [spsg_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  kind_i,
  input  logic [spsg_pkg::SYNC_W-1:0]           sync_age_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [spsg_pkg::SAMPLE_W-1:0]  sample_out_o
);

  spsg_pkg::cfg_t cfg_q, cfg_d;
  spsg_pkg::res_t res;
  logic           core_ready;
  logic           out_free;
  logic           out_valid_q, out_valid_d;
  logic signed [spsg_pkg::SAMPLE_W-1:0] sample_q, sample_d;

  // register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        spsg_pkg::REG_WAVE_TYPE:       cfg_d.wave_type       = cfg_data_i[spsg_pkg::WAVE_W-1:0];
        spsg_pkg::REG_LEVEL:           cfg_d.level           = cfg_data_i[spsg_pkg::LEVEL_W-1:0];
        spsg_pkg::REG_PULSE_WIDTH:     cfg_d.pulse_width     = cfg_data_i;
        spsg_pkg::REG_PULSE_WIDTH_INV: cfg_d.pulse_width_inv = cfg_data_i;
        spsg_pkg::REG_FADE_INV:        cfg_d.fade_inv        = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wave_type       <= spsg_pkg::RST_WAVE_TYPE;
      cfg_q.level           <= spsg_pkg::RST_LEVEL;
      cfg_q.pulse_width     <= spsg_pkg::RST_PULSE_WIDTH;
      cfg_q.pulse_width_inv <= spsg_pkg::RST_PULSE_WIDTH_INV;
      cfg_q.fade_inv        <= spsg_pkg::RST_FADE_INV;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  spsg_core #(
    .TIME_INT_BITS (TIME_INT_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .start_i    (in_valid_i & core_ready),
    .kind_i     (kind_i),
    .sync_age_i (sync_age_i),
    .ready_o    (core_ready),
    .out_free_i (out_free),
    .res_o      (res)
  );

  // output register
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_d = res.valid || (out_valid_q && !out_ready_i);
  assign sample_d    = res.valid ? res.sample : sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
  end

  assign in_ready_o   = core_ready;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_q;

endmodule
